/* sv/qfs_pkg.sv */
// qfs_pkg: shared constants and controller/datapath handshake types for the
// quoted field splitter. No dependencies.
`timescale 1ns / 1ps

package qfs_pkg;

    localparam logic [7:0] QUOTE_CHAR  = 8'h22;
    localparam logic [7:0] EOL_CHAR    = 8'h00;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam int FIELD_DEPTH_DEF = 64;
    localparam int FIELD_DEPTH_MAX = 1024;

    // Configuration port: one 32-bit register at byte address 0.
    localparam int  APB_ADDR_W  = 3;
    localparam int  APB_DATA_W  = 32;
    localparam logic REG_DELIM  = 1'b0;

    typedef struct packed {
        logic take;   // input beat accepted this cycle
        logic rd;     // read the field store at the drain pointer
        logic load;   // load the output register
    } t_qfs_cmd;

    typedef struct packed {
        logic field_end; // the offered character closes a field
        logic empty;     // no characters left to drain, field is empty
        logic last;      // exactly one character left to drain
        logic out_free;  // output register can take a new beat
    } t_qfs_sts;

endpackage

/* sv/qfs_ifs.sv */
// Stream interfaces for the quoted field splitter: character input and
// field output channels with valid/ready handshake. No dependencies.
`timescale 1ns / 1ps

interface qfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface qfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] field_char;
    logic       char_valid;
    logic       last_of_field;
    logic [7:0] field_index;
    logic       overflow;

    modport source (output valid, output field_char, output char_valid,
                    output last_of_field, output field_index, output overflow,
                    input ready);
    modport sink   (input valid, input field_char, input char_valid,
                    input last_of_field, input field_index, input overflow,
                    output ready);
endinterface

/* sv/qfs_ctrl.sv */
// qfs_ctrl: controller state machine of the quoted field splitter. Sequences
// character intake and the drain of a finished field. Depends on qfs_pkg.
`timescale 1ns / 1ps

module qfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  qfs_pkg::t_qfs_sts i_sts,
    output qfs_pkg::t_qfs_cmd o_cmd
);
    import qfs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_sts.field_end) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                // An empty field has nothing to fetch from the store.
                o_cmd.rd = !i_sts.empty;
                n_state  = ST_LD;
            end
            ST_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.empty || i_sts.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/qfs_dp.sv */
// qfs_dp: datapath of the quoted field splitter. Holds the field store,
// line state, drain pointer and the output register. Depends on qfs_pkg.
`timescale 1ns / 1ps

module qfs_dp #(
    parameter int FIELD_DEPTH = qfs_pkg::FIELD_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qfs_pkg::t_qfs_cmd i_cmd,
    output qfs_pkg::t_qfs_sts o_sts,
    input  logic [7:0]        i_char,
    input  logic [7:0]        i_delim,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_field_char,
    output logic              o_char_valid,
    output logic              o_last_of_field,
    output logic [7:0]        o_field_index,
    output logic              o_overflow
);
    import qfs_pkg::*;

    localparam int AW    = $clog2(FIELD_DEPTH);
    localparam int LEN_W = $clog2(FIELD_DEPTH + 1);

    logic [7:0]       r_mem [FIELD_DEPTH];
    logic [7:0]       r_rd_data;

    logic [LEN_W-1:0] r_len;
    logic             r_in_quotes;
    logic [7:0]       r_field_count;
    logic             r_truncated;
    logic             r_first_quote;
    logic             r_last_quote;

    logic [AW-1:0]    r_ptr;
    logic [LEN_W-1:0] r_rem;
    logic [7:0]       r_emit_index;
    logic             r_emit_trunc;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_cvalid;
    logic             r_out_last;
    logic [7:0]       r_out_index;
    logic             r_out_ovf;

    logic is_eol;
    logic is_quote;
    logic is_delim;
    logic len_nz;
    logic has_room;
    logic strip;
    logic do_store;

    assign is_eol   = (i_char == EOL_CHAR);
    assign is_quote = (i_char == QUOTE_CHAR);
    assign is_delim = !is_eol && !r_in_quotes && (i_char == i_delim);
    assign len_nz   = (r_len != '0);
    assign has_room = (r_len < LEN_W'(FIELD_DEPTH));
    assign strip    = (r_len >= LEN_W'(2)) && r_first_quote && r_last_quote;
    assign do_store = i_cmd.take && !is_eol && !is_delim && has_room;

    always_comb begin
        o_sts.field_end = is_delim || (is_eol && len_nz);
        o_sts.empty     = (r_rem == '0);
        o_sts.last      = (r_rem == LEN_W'(1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // Field store: one write port for intake, one registered read port for the drain.
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_mem[r_len[AW-1:0]] <= i_char;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_in_quotes   <= 1'b0;
            r_field_count <= '0;
            r_truncated   <= 1'b0;
            r_first_quote <= 1'b0;
            r_last_quote  <= 1'b0;
            r_rem         <= '0;
        end else if (i_cmd.take) begin
            if (o_sts.field_end) begin
                r_ptr        <= strip ? AW'(1) : '0;
                r_rem        <= strip ? (r_len - LEN_W'(2)) : r_len;
                r_emit_index <= r_field_count;
                r_emit_trunc <= r_truncated;
            end
            if (is_eol || is_delim) begin
                r_len       <= '0;
                r_in_quotes <= 1'b0;
                r_truncated <= 1'b0;
                if (is_eol) begin
                    r_field_count <= '0;
                end else if (r_field_count != 8'hFF) begin
                    r_field_count <= r_field_count + 8'd1;
                end
            end else begin
                // A quote toggles the flag even when it is dropped for lack of room.
                if (is_quote) begin
                    r_in_quotes <= !r_in_quotes;
                end
                if (has_room) begin
                    r_len        <= r_len + LEN_W'(1);
                    r_last_quote <= is_quote;
                    if (!len_nz) begin
                        r_first_quote <= is_quote;
                    end
                end else begin
                    r_truncated <= 1'b1;
                end
            end
        end else if (i_cmd.load && !o_sts.empty) begin
            r_rem <= r_rem - LEN_W'(1);
            r_ptr <= r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_char   <= o_sts.empty ? 8'h00 : r_rd_data;
            r_out_cvalid <= !o_sts.empty;
            r_out_last   <= o_sts.empty || o_sts.last;
            r_out_index  <= r_emit_index;
            r_out_ovf    <= r_emit_trunc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_field_char    = r_out_char;
    assign o_char_valid    = r_out_cvalid;
    assign o_last_of_field = r_out_last;
    assign o_field_index   = r_out_index;
    assign o_overflow      = r_out_ovf;

endmodule

/* sv/quoted_field_splitter.sv */
// quoted_field_splitter: top level. A character that does not close a field leaves intake
// open for the next one. A closing character starts a drain: each beat takes a store read,
// then an output load, which waits while the output register still holds a beat; input waits
// until the drain ends. An empty field gives one beat. Synchronous active-low reset clears the
// line state and sets the delimiter to a comma; the field store is not cleared.
`timescale 1ns / 1ps

module quoted_field_splitter #(
    parameter int FIELD_DEPTH = qfs_pkg::FIELD_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qfs_in_if.sink                          i_char,
    qfs_out_if.source                       o_field,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qfs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qfs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qfs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import qfs_pkg::*;

    logic [7:0] r_delim;
    logic       sel_delim;
    t_qfs_cmd   w_cmd;
    t_qfs_sts   w_sts;

    assign sel_delim = (paddr[APB_ADDR_W-1:2] == REG_DELIM);
    assign pready    = 1'b1;
    assign prdata    = sel_delim ? {{(APB_DATA_W-8){1'b0}}, r_delim} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (psel && penable && pwrite && sel_delim) begin
            r_delim <= pwdata[7:0];
        end
    end

    qfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .o_in_ready (i_char.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qfs_dp #(
        .FIELD_DEPTH (FIELD_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_char          (i_char.char_in),
        .i_delim         (r_delim),
        .i_out_ready     (o_field.ready),
        .o_out_valid     (o_field.valid),
        .o_field_char    (o_field.field_char),
        .o_char_valid    (o_field.char_valid),
        .o_last_of_field (o_field.last_of_field),
        .o_field_index   (o_field.field_index),
        .o_overflow      (o_field.overflow)
    );

    // The output register is only loaded when its previous beat has gone.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_sts.out_free)
        else $error("output register loaded while a beat was still held");

    // A character that closes a field stops intake until the drain is done.
    a_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.take && w_sts.field_end) |=> !i_char.ready)
        else $error("input accepted during a field drain");

    // A store read is always followed by a load attempt, never by intake.
    a_rd_then_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |=> (!i_char.ready && !w_cmd.rd))
        else $error("store read not followed by an output load step");

    // Intake and drain never overlap.
    a_take_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.take |-> (!w_cmd.rd && !w_cmd.load))
        else $error("intake overlapped with the drain");

endmodule
